### src/lz78_pkg.sv
// ----------------------------------------------------------------------------
// lz78_pkg
// Shared constants and types of the LZ78 dictionary encoder.
// ----------------------------------------------------------------------------
package lz78_pkg;
	localparam int MAX_WIDTH_DEF   = 12;
	localparam int TABLE_SLOTS_DEF = 8192;
	localparam int BYTE_W          = 8;
	localparam int CFG_W           = 4;
	localparam int IDX_W           = 13;
	localparam int CW_W            = 4;
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd12;
	localparam logic [31:0] HASH_MUL = 32'd2654435761;
	localparam int HASH_SHIFT = 7;

	// controller -> datapath commands
	typedef struct packed {
		logic take;     // latch input item, start hash
		logic hash2;    // second hash stage
		logic rd;       // issue read at probe position
		logic adv;      // step probe position
		logic wr;       // write new entry at probe position
		logic tok;      // load output token
		logic fin;      // token is flush token
		logic upd;      // update match/width after token
		logic match;    // follow found entry
		logic clr;      // start clear sweep
		logic clr_step; // clear one slot
	} cmd_t;

	typedef struct packed {
		logic first;     // dictionary empty
		logic hit;       // probed slot matches
		logic empty;     // probed slot empty
		logic wrapped;   // probe walked all slots
		logic eoi;       // latched end flag
		logic over;      // width above limit after update
		logic clr_done;  // clear sweep at last slot
	} sts_t;
endpackage

### src/lz78_if.sv
// ----------------------------------------------------------------------------
// lz78 stream interfaces
// Valid/ready channels for input bytes and output tokens.
// ----------------------------------------------------------------------------
interface lz78_in_if;
	logic valid;
	logic ready;
	logic [lz78_pkg::BYTE_W-1:0] data_byte;
	logic end_of_input;
	modport source (output valid, data_byte, end_of_input, input ready);
	modport sink (input valid, data_byte, end_of_input, output ready);
endinterface

interface lz78_out_if;
	logic valid;
	logic ready;
	logic [lz78_pkg::IDX_W-1:0] code_index;
	logic [lz78_pkg::CW_W-1:0] code_width;
	logic [lz78_pkg::BYTE_W-1:0] literal;
	logic final_token;
	modport source (output valid, code_index, code_width, literal, final_token, input ready);
	modport sink (input valid, code_index, code_width, literal, final_token, output ready);
endinterface

### src/lz78_datapath.sv
// ----------------------------------------------------------------------------
// lz78_datapath
// Hash table memory, probe address, match and width registers, output token.
// ----------------------------------------------------------------------------
module lz78_datapath (
	input  logic clk,
	input  logic arst_n,
	input  lz78_pkg::cmd_t cmd,
	output lz78_pkg::sts_t sts,
	input  logic [lz78_pkg::BYTE_W-1:0] in_byte,
	input  logic in_eoi,
	input  logic [lz78_pkg::CFG_W-1:0] max_code_bits,
	output logic [lz78_pkg::IDX_W-1:0] tok_index,
	output logic [lz78_pkg::CW_W-1:0] tok_width,
	output logic [lz78_pkg::BYTE_W-1:0] tok_literal,
	output logic tok_final
);
	localparam int MAX_WIDTH   = lz78_pkg::MAX_WIDTH_DEF;
	localparam int TABLE_SLOTS = lz78_pkg::TABLE_SLOTS_DEF;
	localparam int AW = $clog2(TABLE_SLOTS);
	localparam int IW = lz78_pkg::IDX_W;
	localparam int EW = 1 + IW + lz78_pkg::BYTE_W + IW; // used,parent,byte,idx

	logic [EW-1:0] mem [TABLE_SLOTS];
	logic [EW-1:0] rd_q;
	logic [AW-1:0] pos_q, clr_q;
	logic [AW:0] cnt_q;
	logic [lz78_pkg::BYTE_W-1:0] byte_q;
	logic eoi_q;
	logic [IW-1:0] match_q, next_q;
	logic [lz78_pkg::CW_W-1:0] width_q;
	logic [31:0] prod_s1;
	logic [IW+lz78_pkg::BYTE_W-1:0] key;
	logic [31:0] prod_full;
	logic [lz78_pkg::CW_W-1:0] lim;
	logic [IW-1:0] next_inc;
	logic [lz78_pkg::CW_W-1:0] width_nx;

	assign key = {match_q, in_byte};
	// only the low product bits reach the slot position
	assign prod_full = {11'd0, key} * lz78_pkg::HASH_MUL;

	// clamp the limit into 1..MAX_WIDTH
	always_comb begin
		lim = max_code_bits;
		if (lim == '0) lim = 4'd1;
		if (32'(lim) > MAX_WIDTH) lim = lz78_pkg::CW_W'(MAX_WIDTH);
	end

	assign next_inc = next_q + 1'b1;
	assign width_nx = ((32'(next_q)) == (32'd1 << width_q)) ? width_q + 1'b1 : width_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q  <= in_byte;
			prod_s1 <= prod_full;
		end
		if (cmd.hash2) begin
			pos_q <= AW'(prod_s1 >> lz78_pkg::HASH_SHIFT);
			cnt_q <= '0;
		end else if (cmd.adv) begin
			pos_q <= pos_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.rd) rd_q <= mem[pos_q];
		if (cmd.clr_step) mem[clr_q] <= '0;
		else if (cmd.wr) mem[pos_q] <= {1'b1, match_q, byte_q, next_q};
		if (cmd.tok) begin
			tok_index   <= match_q;
			tok_width   <= width_q;
			tok_literal <= byte_q;
			tok_final   <= cmd.fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eoi_q   <= 1'b0;
			match_q <= '0;
			next_q  <= IW'(1);
			width_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.take) eoi_q <= in_eoi;
			if (cmd.clr) begin
				match_q <= '0;
				next_q  <= IW'(1);
				width_q <= '0;
				clr_q   <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end else if (cmd.upd) begin
				match_q <= '0;
				next_q  <= next_inc;
				width_q <= width_nx;
			end else if (cmd.match) begin
				match_q <= rd_q[IW-1:0];
			end
		end
	end

	assign sts.first    = (next_q == IW'(1));
	assign sts.hit      = rd_q[EW-1] && (rd_q[EW-2 -: IW] == match_q)
		&& (rd_q[IW +: lz78_pkg::BYTE_W] == byte_q);
	assign sts.empty    = !rd_q[EW-1];
	assign sts.wrapped  = (cnt_q == (AW+1)'(TABLE_SLOTS));
	assign sts.eoi      = eoi_q;
	// width that the pending update produces, against the limit
	assign sts.over     = (width_nx > lim);
	assign sts.clr_done = (clr_q == AW'(TABLE_SLOTS - 1));
endmodule

### src/lz78_ctrl.sv
// ----------------------------------------------------------------------------
// lz78_ctrl
// Sequencer: hash, probe, insert, token, clear sweep.
// ----------------------------------------------------------------------------
module lz78_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output lz78_pkg::cmd_t cmd,
	input  lz78_pkg::sts_t sts
);
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_HASH = 3'd2;
	localparam logic [2:0] S_RD   = 3'd3;
	localparam logic [2:0] S_CHK  = 3'd4;
	localparam logic [2:0] S_INS  = 3'd5; // probing for a free slot
	localparam logic [2:0] S_ICHK = 3'd6;
	localparam logic [2:0] S_POST = 3'd7;

	logic [2:0] state_q, state_nx;
	logic ov_q, ov_nx;
	logic tok_ok;

	// token register may be loaded when empty or leaving this cycle
	assign tok_ok = !ov_q || out_ready;
	assign out_valid = ov_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_nx = state_q;
		ov_nx = ov_q && !out_ready;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_nx = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash2 = 1'b1;
				state_nx = S_RD;
			end
			S_RD: begin
				cmd.rd = 1'b1;
				state_nx = sts.first ? S_ICHK : S_CHK;
			end
			S_CHK: begin
				if (!sts.empty && !sts.hit && !sts.wrapped) begin
					cmd.adv = 1'b1;
					state_nx = S_RD;
				end else if (sts.hit && !sts.wrapped) begin
					if (sts.eoi) begin
						if (tok_ok) begin
							cmd.tok = 1'b1;
							cmd.fin = 1'b1;
							ov_nx = 1'b1;
							cmd.clr = 1'b1;
							state_nx = S_CLR;
						end
					end else begin
						cmd.match = 1'b1;
						state_nx = S_IDLE;
					end
				end else begin
					// miss: empty slot at pos already, or table full
					state_nx = S_ICHK;
				end
			end
			S_ICHK: begin
				if (tok_ok) begin
					if (sts.empty && !sts.wrapped) cmd.wr = 1'b1;
					cmd.tok = 1'b1;
					ov_nx = 1'b1;
					state_nx = S_POST;
				end
			end
			S_INS: begin
				cmd.rd = 1'b1;
				state_nx = S_ICHK;
			end
			S_POST: begin
				cmd.upd = 1'b1;
				// clear when the grown width passes the limit or the stream ends
				if (sts.over || sts.eoi) begin
					cmd.clr = 1'b1;
					state_nx = S_CLR;
				end else begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ov_q <= 1'b0;
		end else begin
			ov_q <= ov_nx;
			state_q <= state_nx;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLR) |-> !in_ready)
		else $error("input taken during clear");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tok |-> tok_ok)
		else $error("token overwrite");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("token lost");
endmodule

### src/lz78_dictionary_encoder_unit.sv
// ----------------------------------------------------------------------------
// lz78_dictionary_encoder_unit
// LZ78 encoder with a hash-table dictionary, one byte per transfer.
// ----------------------------------------------------------------------------
// A byte is taken in and hashed first; each probe of the single-port
// table then reads a slot and compares it. A byte that extends the phrase
// ends there, a byte that adds an entry goes on to insert and update, and
// the first entry of a dictionary skips the compare.
// A token waits in the one output register while the receiver stalls, and the
// sequence holds with it. After reset, after each end-of-stream byte and
// whenever the width passes the limit, a clearing pass runs through every
// table slot; no input is taken then.
module lz78_dictionary_encoder_unit (
	input  logic clk,
	input  logic arst_n,
	lz78_in_if.sink   in_ch,
	lz78_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [lz78_pkg::CFG_W-1:0] cfg_wdata
);
	lz78_pkg::cmd_t cmd;
	lz78_pkg::sts_t sts;
	logic [lz78_pkg::CFG_W-1:0] max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_q <= lz78_pkg::CFG_RESET;
		else if (cfg_we) max_q <= cfg_wdata;
	end

	lz78_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd, .sts
	);

	lz78_datapath u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_byte(in_ch.data_byte), .in_eoi(in_ch.end_of_input),
		.max_code_bits(max_q),
		.tok_index(out_ch.code_index), .tok_width(out_ch.code_width),
		.tok_literal(out_ch.literal), .tok_final(out_ch.final_token)
	);
endmodule

### tb/lz78_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lz78 stream interfaces (testbench side)
// The bench uses the valid/ready interfaces from src/lz78_if.sv.
// ----------------------------------------------------------------------------

### tb/tb_lz78_dictionary_encoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lz78_dictionary_encoder_unit
// Drives byte streams into the LZ78 encoder and checks every output token
// against a directed table or an in-bench dictionary model, across several
// limit settings and with random idle on the input and stall on the output.
// ----------------------------------------------------------------------------
module tb_lz78_dictionary_encoder_unit;
	localparam int  SLOTS     = lz78_pkg::TABLE_SLOTS_DEF;
	localparam int  DRAIN_CYC = lz78_pkg::TABLE_SLOTS_DEF + 200;
	localparam longint CYCLE_LIMIT = 4000000;

	localparam int ROW_PRED = 0;
	localparam int ROW_TOK  = 1;
	localparam int ROW_NONE = 2;

	typedef struct {
		logic [lz78_pkg::IDX_W-1:0]  idx;
		logic [lz78_pkg::CW_W-1:0]   width;
		logic [lz78_pkg::BYTE_W-1:0] lit;
		logic                        fin;
	} token_t;

	typedef struct {
		logic [lz78_pkg::BYTE_W-1:0] b;
		logic                        eoi;
		int                          kind;
		token_t                      tok;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [lz78_pkg::CFG_W-1:0] cfg_wdata = '0;

	lz78_in_if  in_ch();
	lz78_out_if out_ch();

	lz78_dictionary_encoder_unit DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// dictionary model state
	bit                          slot_used [SLOTS];
	logic [lz78_pkg::IDX_W-1:0]  slot_parent [SLOTS];
	logic [lz78_pkg::IDX_W-1:0]  slot_idx [SLOTS];
	logic [lz78_pkg::BYTE_W-1:0] slot_byte [SLOTS];
	int unsigned next_entry, width_now, cur_match;
	logic [lz78_pkg::CFG_W-1:0] max_bits_reg;

	token_t expected_tokens[$];
	int errors = 0;
	longint cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	function automatic int unsigned slot_hash(int unsigned parent, int unsigned b);
		longint unsigned key, h;
		key = (64'(parent) << 8) | 64'(b);
		h = (key * 64'd2654435761) >> 7;
		return 32'(h % 64'(SLOTS));
	endfunction

	function automatic void dict_clear();
		for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
		next_entry = 1;
		width_now = 0;
		cur_match = 0;
	endfunction

	function automatic bit dict_find(int unsigned parent, int unsigned b, output int unsigned hit);
		int unsigned pos;
		pos = slot_hash(parent, b);
		hit = 0;
		for (int n = 0; n < SLOTS; n++) begin
			if (!slot_used[pos]) return 1'b0;
			if (slot_parent[pos] == parent && slot_byte[pos] == b) begin
				hit = 32'(slot_idx[pos]);
				return 1'b1;
			end
			pos = (pos + 1 == SLOTS) ? 0 : pos + 1;
		end
		return 1'b0;
	endfunction

	function automatic void dict_add(int unsigned parent, int unsigned b, int unsigned id);
		int unsigned pos;
		pos = slot_hash(parent, b);
		for (int n = 0; n < SLOTS; n++) begin
			if (!slot_used[pos]) begin
				slot_used[pos] = 1'b1;
				slot_parent[pos] = lz78_pkg::IDX_W'(parent);
				slot_byte[pos] = lz78_pkg::BYTE_W'(b);
				slot_idx[pos] = lz78_pkg::IDX_W'(id);
				return;
			end
			pos = (pos + 1 == SLOTS) ? 0 : pos + 1;
		end
	endfunction

	// advance the encoder model by one byte; returns 1 when a token results
	function automatic bit encode_byte(logic [lz78_pkg::BYTE_W-1:0] b, logic eoi,
			output token_t t);
		int unsigned lim, hit;
		lim = 32'(max_bits_reg);
		if (lim < 1) lim = 1;
		if (lim > lz78_pkg::MAX_WIDTH_DEF) lim = lz78_pkg::MAX_WIDTH_DEF;
		t = '{idx: '0, width: '0, lit: b, fin: 1'b0};
		if (next_entry == 1) begin
			dict_add(0, 32'(b), 1);
			next_entry = 2;
			width_now = 1;
			cur_match = 0;
			if (eoi) dict_clear();
			return 1'b1;
		end
		if (dict_find(cur_match, 32'(b), hit)) begin
			if (eoi) begin
				t = '{idx: lz78_pkg::IDX_W'(cur_match), width: lz78_pkg::CW_W'(width_now),
					lit: b, fin: 1'b1};
				dict_clear();
				return 1'b1;
			end
			cur_match = hit;
			return 1'b0;
		end
		dict_add(cur_match, 32'(b), next_entry);
		t = '{idx: lz78_pkg::IDX_W'(cur_match), width: lz78_pkg::CW_W'(width_now),
			lit: b, fin: 1'b0};
		next_entry++;
		if (next_entry - 1 == (1 << width_now)) width_now++;
		cur_match = 0;
		if (width_now > lim || eoi) dict_clear();
		return 1'b1;
	endfunction

	// hand one byte over and record what it should produce
	task automatic send_byte(logic [lz78_pkg::BYTE_W-1:0] b, logic eoi, int kind,
			token_t typed);
		token_t t;
		bit has;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.data_byte = b;
		in_ch.end_of_input = eoi;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		has = encode_byte(b, eoi, t);
		if (kind == ROW_TOK) expected_tokens = {expected_tokens, typed};
		else if (kind == ROW_PRED && has) expected_tokens = {expected_tokens, t};
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic drain_and_settle();
		while (expected_tokens.size() != 0) @(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);
	endtask

	task automatic write_limit(logic [lz78_pkg::CFG_W-1:0] v);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		max_bits_reg = v;
	endtask

	task automatic random_phase(logic [lz78_pkg::CFG_W-1:0] lim, int idle, int stall,
			int count, bit hold_mid);
		logic [lz78_pkg::BYTE_W-1:0] b;
		drain_and_settle();
		write_limit(lim);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++) begin
			// mostly a small alphabet so phrases repeat and chains grow long
			if ($urandom_range(0, 9) < 8) b = 8'($urandom_range(0, 3) + 32'h61);
			else b = 8'($urandom_range(0, 255));
			if (hold_mid && i == count / 2)
				while (expected_tokens.size() != 0) @(negedge clk);
			send_byte(b, $urandom_range(0, 99) == 0, ROW_PRED, '{default: '0});
		end
	endtask

	row_t directed[] = '{
		'{8'h00, 1'b0, ROW_TOK,  '{13'd0, 4'd0, 8'h00, 1'b0}},
		'{8'hFF, 1'b0, ROW_TOK,  '{13'd0, 4'd1, 8'hFF, 1'b0}},
		'{8'h00, 1'b0, ROW_NONE, '{default: '0}},
		'{8'h00, 1'b1, ROW_TOK,  '{13'd1, 4'd2, 8'h00, 1'b0}},
		'{8'h41, 1'b0, ROW_TOK,  '{13'd0, 4'd0, 8'h41, 1'b0}},
		'{8'h41, 1'b1, ROW_TOK,  '{13'd0, 4'd1, 8'h41, 1'b1}},
		'{8'h80, 1'b1, ROW_TOK,  '{13'd0, 4'd0, 8'h80, 1'b0}},
		'{8'h7F, 1'b0, ROW_TOK,  '{13'd0, 4'd0, 8'h7F, 1'b0}},
		'{8'h7F, 1'b0, ROW_NONE, '{default: '0}},
		'{8'h7F, 1'b0, ROW_TOK,  '{13'd1, 4'd1, 8'h7F, 1'b0}},
		'{8'h01, 1'b0, ROW_TOK,  '{13'd0, 4'd2, 8'h01, 1'b0}},
		'{8'h01, 1'b1, ROW_TOK,  '{13'd0, 4'd2, 8'h01, 1'b1}},
		'{8'h55, 1'b0, ROW_PRED, '{default: '0}},
		'{8'hAA, 1'b0, ROW_PRED, '{default: '0}},
		'{8'h55, 1'b0, ROW_PRED, '{default: '0}},
		'{8'hAA, 1'b0, ROW_PRED, '{default: '0}},
		'{8'h55, 1'b0, ROW_PRED, '{default: '0}},
		'{8'hAA, 1'b0, ROW_PRED, '{default: '0}},
		'{8'h0F, 1'b0, ROW_PRED, '{default: '0}},
		'{8'hF0, 1'b0, ROW_PRED, '{default: '0}},
		'{8'hFE, 1'b0, ROW_PRED, '{default: '0}},
		'{8'h10, 1'b0, ROW_PRED, '{default: '0}},
		'{8'h20, 1'b1, ROW_PRED, '{default: '0}}
	};

	// receiver back-pressure
	always @(negedge clk)
		out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

	// token checker
	always @(posedge clk) begin
		token_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_tokens.size() == 0) begin
				$error("unexpected token idx=%0d width=%0d lit=%0h fin=%0b",
					out_ch.code_index, out_ch.code_width, out_ch.literal,
					out_ch.final_token);
				errors++;
			end else begin
				e = expected_tokens.pop_front();
				if (out_ch.code_index !== e.idx) begin
					$error("code_index expected %0d actual %0d", e.idx, out_ch.code_index);
					errors++;
				end
				if (out_ch.code_width !== e.width) begin
					$error("code_width expected %0d actual %0d", e.width, out_ch.code_width);
					errors++;
				end
				if (out_ch.literal !== e.lit) begin
					$error("literal expected %0h actual %0h", e.lit, out_ch.literal);
					errors++;
				end
				if (out_ch.final_token !== e.fin) begin
					$error("final_token expected %0b actual %0b", e.fin, out_ch.final_token);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_lz78_dictionary_encoder_unit: done, errors");
			$finish;
		end
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.end_of_input = 1'b0;
		max_bits_reg = lz78_pkg::CFG_RESET;
		dict_clear();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_byte(directed[i].b, directed[i].eoi, directed[i].kind, directed[i].tok);

		random_phase(4'd12, 0, 0, 300, 1'b0);
		random_phase(4'd3, 70, 0, 30, 1'b0);
		random_phase(4'd1, 0, 70, 15, 1'b0);
		random_phase(4'd0, 18, 18, 10, 1'b0);
		random_phase(4'd15, 18, 18, 300, 1'b1);
		random_phase(4'd12, 0, 70, 350, 1'b0);
		random_phase(4'd8, 0, 0, 200, 1'b0);

		idle_pct = 0;
		stall_pct = 0;
		drain_and_settle();
		if (errors == 0 && expected_tokens.size() == 0)
			$display("tb_lz78_dictionary_encoder_unit: done, clean");
		else
			$display("tb_lz78_dictionary_encoder_unit: done, errors");
		$finish;
	end
endmodule
